// ===== rtl/imu_cal_pkg.sv =====
// ----------------------------------------------------------------------------
// imu_cal_pkg
// Shared widths, codes and helpers for the IMU scale and bias calibration.
// ----------------------------------------------------------------------------
package imu_cal_pkg;

    // field widths
    localparam int RAW_W    = 16;
    localparam int VAL_W    = 32;
    localparam int SUM_W    = 48;
    localparam int CNT_W    = 16;
    localparam int RANGE_W  = 2;
    localparam int KIND_W   = 2;
    localparam int NUM_AXES = 6;
    localparam int NUM_OFFS = 5;

    // port widths
    localparam int S_DATA_W  = NUM_AXES * RAW_W;
    localparam int M_DATA_W  = NUM_AXES * VAL_W;
    localparam int M_USER_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // divider: 48-bit dividend, divisor up to 65536
    localparam int DIV_W     = CNT_W + 1;
    localparam int STEP_W    = $clog2(SUM_W);

    // frame kinds
    localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CALIB   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MEASURE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CALIB_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_RANGE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_RANGE = 2'd2;

    // reset values of the registers
    localparam logic [CNT_W-1:0]   CALIB_COUNT_RST = 16'd256;
    localparam logic [RANGE_W-1:0] GYRO_RANGE_RST  = 2'd2;
    localparam logic [RANGE_W-1:0] ACCEL_RANGE_RST = 2'd3;

    // accel shift base: Q8.24 g = raw << (10 + range)
    localparam logic [4:0] ACCEL_SHIFT_BASE = 5'd10;

    // round(2^24 * pi / (180 * LSB)) for 250/500/1000/2000 deg/s
    function automatic logic [14:0] rate_mult(input logic [RANGE_W-1:0] rng);
        logic [14:0] m;
        case (rng)
            2'd0:    m = 15'd2235;
            2'd1:    m = 15'd4470;
            2'd2:    m = 15'd8927;
            default: m = 15'd17855;
        endcase
        return m;
    endfunction

    // clamp a 49-bit signed value to signed 32 bits
    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [SUM_W:0] v);
        logic signed [VAL_W-1:0] r;
        if (v > 49'sh0_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -49'sh0_0000_8000_0000) begin
            r = -32'sh8000_0000;
        end else begin
            r = v[VAL_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/imu_scale_and_bias_calibration_top.sv =====
// ----------------------------------------------------------------------------
// imu_scale_and_bias_calibration_top
// Scales six-axis IMU frames to Q8.24 and learns and removes axis biases.
// ----------------------------------------------------------------------------
// One frame is handled at a time by a small sequencer around a shared scale
// unit (accel shifter / gyro 16x15 multiplier), a shared subtract-saturate
// adder and a restoring divider that yields one quotient bit per cycle.
// A clear frame or an unused kind goes from the idle state straight to the
// finish state. Calibration and measurement frames walk the six axes through
// the scale unit, a scale step and an accumulate step per axis. A calibration
// frame that ends a run then forms five rounded means in the divider, each
// by a set-up step, 48 quotient bits and an offset update. A result waits in
// the output register while the next frame is already taken and worked on;
// the input is ready whenever the sequencer is idle.
// ----------------------------------------------------------------------------
module imu_scale_and_bias_calibration_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input frames
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // raw_accel_x, raw_accel_y, raw_accel_z, raw_gyro_x, raw_gyro_y, raw_gyro_z
    input  logic [imu_cal_pkg::S_DATA_W-1:0]   s_tdata,
    // kind
    input  logic [imu_cal_pkg::KIND_W-1:0]     s_tuser,
    // results
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
    output logic [imu_cal_pkg::M_DATA_W-1:0]   m_tdata,
    // is_measurement, calibration_done
    output logic [imu_cal_pkg::M_USER_W-1:0]   m_tuser,
    // register writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [imu_cal_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [imu_cal_pkg::CFG_DAT_W-1:0]  cfg_data
);
    import imu_cal_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_ACC,
        ST_DIV_PREP,
        ST_DIV,
        ST_APPLY,
        ST_FINISH
    } state_t;

    typedef logic signed [RAW_W-1:0] raw_arr_t [NUM_AXES];
    typedef logic signed [VAL_W-1:0] val_arr_t [NUM_AXES];
    typedef logic signed [VAL_W-1:0] off_arr_t [NUM_OFFS];
    typedef logic signed [SUM_W-1:0] sum_arr_t [NUM_OFFS];

    state_t                    state_reg,   state_next;
    logic [2:0]                axis_reg,    axis_next;
    logic [2:0]                slot_reg,    slot_next;
    logic [STEP_W-1:0]         step_reg,    step_next;
    logic [KIND_W-1:0]         kind_reg,    kind_next;
    raw_arr_t                  raw_reg,     raw_next;
    logic signed [VAL_W-1:0]   scaled_reg,  scaled_next;
    val_arr_t                  res_reg,     res_next;
    logic                      done_reg,    done_next;
    logic [CNT_W-1:0]          cnt_reg,     cnt_next;
    logic [RANGE_W-1:0]        grange_reg,  grange_next;
    logic [RANGE_W-1:0]        arange_reg,  arange_next;
    off_arr_t                  off_reg,     off_next;
    sum_arr_t                  sum_reg,     sum_next;
    logic [CNT_W-1:0]          samples_reg, samples_next;
    logic [SUM_W-1:0]          quo_reg,     quo_next;
    logic [DIV_W-1:0]          rem_reg,     rem_next;
    logic                      neg_reg,     neg_next;
    logic [DIV_W-1:0]          eff_reg,     eff_next;
    logic                      m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]       m_tdata_reg,  m_tdata_next;
    logic [M_USER_W-1:0]       m_tuser_reg,  m_tuser_next;

    // shared scale unit
    logic signed [RAW_W-1:0]   raw_sel;
    logic signed [VAL_W-1:0]   accel_val;
    logic signed [VAL_W-1:0]   gyro_val;
    // axis to offset slot
    logic                      has_off;
    logic [2:0]                axis_slot;
    // shared adder
    logic signed [SUM_W:0]     diff_val;
    // run bookkeeping
    logic [DIV_W-1:0]          n_val;
    logic [DIV_W-1:0]          eff_val;
    // divider step
    logic [DIV_W:0]            rem_sh;
    logic                      rem_ge;
    // mean and offset update
    logic signed [SUM_W-1:0]   sum_sel;
    logic [SUM_W-1:0]          mag_val;
    logic signed [SUM_W-1:0]   mean_val;
    logic signed [SUM_W:0]     tot_val;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    // scale unit: shift for accel, table multiply for gyro
    assign raw_sel   = raw_reg[axis_reg];
    assign accel_val = VAL_W'(raw_sel) <<< (ACCEL_SHIFT_BASE + 5'(arange_reg));
    assign gyro_val  = raw_sel * $signed({1'b0, rate_mult(grange_reg)});

    // offset slots: ax, ay, gx, gy, gz; z accel has none
    always_comb begin
        has_off   = 1'b1;
        axis_slot = 3'd0;
        case (axis_reg)
            3'd0:    axis_slot = 3'd0;
            3'd1:    axis_slot = 3'd1;
            3'd2:    has_off   = 1'b0;
            3'd3:    axis_slot = 3'd2;
            3'd4:    axis_slot = 3'd3;
            3'd5:    axis_slot = 3'd4;
            default: has_off   = 1'b0;
        endcase
    end

    // measured value minus offset
    assign diff_val = (SUM_W+1)'(scaled_reg)
                    - (has_off ? (SUM_W+1)'(off_reg[axis_slot]) : '0);

    // samples in the run including this one; zero count means 65536
    assign n_val   = DIV_W'(samples_reg) + DIV_W'(1);
    assign eff_val = (cnt_reg == '0) ? {1'b1, {CNT_W{1'b0}}} : DIV_W'(cnt_reg);

    // restoring divider, one quotient bit per cycle
    assign rem_sh = {rem_reg, quo_reg[SUM_W-1]};
    assign rem_ge = (rem_sh >= (DIV_W+1)'(eff_reg));

    // magnitude of the sum, signed mean, offset update
    assign sum_sel  = sum_reg[slot_reg];
    assign mag_val  = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);
    assign mean_val = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);
    assign tot_val  = (SUM_W+1)'(off_reg[slot_reg]) + (SUM_W+1)'(mean_val);

    // sequencer next state
    always_comb begin
        state_next    = state_reg;
        axis_next     = axis_reg;
        slot_next     = slot_reg;
        step_next     = step_reg;
        kind_next     = kind_reg;
        raw_next      = raw_reg;
        scaled_next   = scaled_reg;
        res_next      = res_reg;
        done_next     = done_reg;
        cnt_next      = cnt_reg;
        grange_next   = grange_reg;
        arange_next   = arange_reg;
        off_next      = off_reg;
        sum_next      = sum_reg;
        samples_next  = samples_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        neg_next      = neg_reg;
        eff_next      = eff_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        // register writes
        if (cfg_valid) begin
            case (cfg_index)
                REG_CALIB_COUNT: cnt_next    = cfg_data;
                REG_GYRO_RANGE:  grange_next = cfg_data[RANGE_W-1:0];
                REG_ACCEL_RANGE: arange_next = cfg_data[RANGE_W-1:0];
                default: ;
            endcase
        end

        // output beat taken
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    kind_next = s_tuser;
                    for (int i = 0; i < NUM_AXES; i++) begin
                        raw_next[i] = s_tdata[i*RAW_W +: RAW_W];
                        res_next[i] = '0;
                    end
                    done_next = 1'b0;
                    axis_next = 3'd0;
                    case (s_tuser)
                        KIND_CLEAR: begin
                            for (int i = 0; i < NUM_OFFS; i++) begin
                                off_next[i] = '0;
                                sum_next[i] = '0;
                            end
                            samples_next = '0;
                            state_next   = ST_FINISH;
                        end
                        KIND_CALIB, KIND_MEASURE: state_next = ST_SCALE;
                        default: state_next = ST_FINISH;
                    endcase
                end
            end
            ST_SCALE: begin
                scaled_next = (axis_reg < 3'd3) ? accel_val : gyro_val;
                state_next  = ST_ACC;
            end
            ST_ACC: begin
                if (kind_reg == KIND_MEASURE) begin
                    res_next[axis_reg] = sat32(diff_val);
                end else if (has_off) begin
                    sum_next[axis_slot] = sum_reg[axis_slot] + SUM_W'(scaled_reg);
                end
                if (axis_reg == 3'(NUM_AXES - 1)) begin
                    if (kind_reg == KIND_CALIB && n_val >= eff_val) begin
                        eff_next   = eff_val;
                        slot_next  = 3'd0;
                        state_next = ST_DIV_PREP;
                    end else begin
                        if (kind_reg == KIND_CALIB) begin
                            samples_next = n_val[CNT_W-1:0];
                        end
                        state_next = ST_FINISH;
                    end
                end else begin
                    axis_next  = axis_reg + 3'd1;
                    state_next = ST_SCALE;
                end
            end
            ST_DIV_PREP: begin
                // round half away from zero: (|sum| + d/2) / d
                neg_next   = sum_sel[SUM_W-1];
                quo_next   = mag_val + SUM_W'(eff_reg >> 1);
                rem_next   = '0;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                rem_next = rem_ge ? DIV_W'(rem_sh - (DIV_W+1)'(eff_reg)) : rem_sh[DIV_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], rem_ge};
                if (step_reg == STEP_W'(SUM_W - 1)) begin
                    state_next = ST_APPLY;
                end else begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_APPLY: begin
                off_next[slot_reg] = sat32(tot_val);
                sum_next[slot_reg] = '0;
                if (slot_reg == 3'(NUM_OFFS - 1)) begin
                    samples_next = '0;
                    done_next    = 1'b1;
                    state_next   = ST_FINISH;
                end else begin
                    slot_next  = slot_reg + 3'd1;
                    state_next = ST_DIV_PREP;
                end
            end
            ST_FINISH: begin
                // load the output register once it is free
                if (!m_tvalid_reg || m_tready) begin
                    for (int i = 0; i < NUM_AXES; i++) begin
                        m_tdata_next[i*VAL_W +: VAL_W] = res_reg[i];
                    end
                    m_tuser_next  = {done_reg, kind_reg == KIND_MEASURE};
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state and registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            cnt_reg      <= CALIB_COUNT_RST;
            grange_reg   <= GYRO_RANGE_RST;
            arange_reg   <= ACCEL_RANGE_RST;
            samples_reg  <= '0;
            for (int i = 0; i < NUM_OFFS; i++) begin
                off_reg[i] <= '0;
                sum_reg[i] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            cnt_reg      <= cnt_next;
            grange_reg   <= grange_next;
            arange_reg   <= arange_next;
            samples_reg  <= samples_next;
            off_reg      <= off_next;
            sum_reg      <= sum_next;
        end
        // datapath registers, no reset needed
        axis_reg    <= axis_next;
        slot_reg    <= slot_next;
        step_reg    <= step_next;
        kind_reg    <= kind_next;
        raw_reg     <= raw_next;
        scaled_reg  <= scaled_next;
        res_reg     <= res_next;
        done_reg    <= done_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        neg_reg     <= neg_next;
        eff_reg     <= eff_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

endmodule
